// ===== src/vgrt_pkg.sv =====
// Package for the voxel grid ray traversal block: widths, codes and types.
// Used by all modules under src.
`timescale 1ns / 1ps
package vgrt_pkg;
    localparam int GRID_BITS_DEF = 4;
    localparam int POS_W = 17;
    localparam int DIR_W = 16;
    localparam int T_W   = 24;
    localparam logic [T_W-1:0] T_MAXVAL = 24'hFFFFFF;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_DIV, ST_STEP, ST_LOOK, ST_OUT
    } vgrt_state_t;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0, FACE_NEG_X = 3'd1, FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3, FACE_POS_Z = 3'd4, FACE_NEG_Z = 3'd5
    } vgrt_face_t;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic clr_start;   // clearing-pass request; held low, the pass runs from reset
        logic load;        // capture cast item, start division
        logic wr;          // grid write
        logic step;        // one DDA step
        logic look;        // evaluate looked-up voxel
    } vgrt_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic zero_dir;
        logic out_grid;    // after step: left the grid
        logic solid;       // after lookup: solid voxel
        logic limit;       // step limit reached
    } vgrt_sts_t;
endpackage

// ===== src/vgrt_ctrl.sv =====
// Controller FSM for the voxel ray traversal block.
// Depends on vgrt_pkg.
`timescale 1ns / 1ps
module vgrt_ctrl import vgrt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        in_action,
    output logic        in_ready,
    output logic        res_valid,
    output logic        res_hit_set,
    input  logic        res_ready,
    output vgrt_cmd_t   cmd,
    input  vgrt_sts_t   sts
);
    vgrt_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        res_hit_set = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_action == ACT_WRITE) begin
                        cmd.wr = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (sts.zero_dir) state_next = ST_OUT;
                else if (sts.div_done) state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                cmd.look = 1'b1;
                if (sts.out_grid || sts.limit) state_next = ST_OUT;
                else if (sts.solid) begin
                    res_hit_set = 1'b1;
                    state_next  = ST_OUT;
                end else state_next = ST_STEP;
            end
            ST_OUT: begin
                res_valid = 1'b1;
                if (res_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.clr_start = 1'b0;
    end
endmodule

// ===== src/vgrt_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating to T_W bits.
// Depends on vgrt_pkg.
`timescale 1ns / 1ps
module vgrt_div import vgrt_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [30:0]    num,
    input  logic [15:0]    den,
    output logic           done,
    output logic [T_W-1:0] quo
);
    logic [30:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[15:0], q_reg[30]};
        if (start) begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = 5'd30;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[29:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[29:0], 1'b0};
            end
            if (cnt_reg == 5'd0) busy_next = 1'b0;
            else cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) d_reg <= den;
    end

    assign done = !busy_reg && !start;
    assign quo  = (q_reg[30:T_W] != '0) ? T_MAXVAL : q_reg[T_W-1:0];
endmodule

// ===== src/vgrt_dp.sv =====
// Datapath: occupancy memory with clearing pass, axis setup, shared divider, DDA step.
// Depends on vgrt_pkg and vgrt_div.
`timescale 1ns / 1ps
module vgrt_dp import vgrt_pkg::*; #(
    parameter int GRID_BITS = GRID_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vgrt_cmd_t             cmd,
    output vgrt_sts_t             sts,
    input  logic [3:0]            vox_x,
    input  logic [3:0]            vox_y,
    input  logic [3:0]            vox_z,
    input  logic                  solid,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic signed [DIR_W-1:0] dir_x,
    input  logic signed [DIR_W-1:0] dir_y,
    input  logic signed [DIR_W-1:0] dir_z,
    input  logic                  hit_set,
    output logic                  hit,
    output logic [3:0]            hit_x,
    output logic [3:0]            hit_y,
    output logic [3:0]            hit_z,
    output logic [2:0]            face
);
    localparam int CELLS  = 1 << (3 * GRID_BITS);
    localparam int AW     = 3 * GRID_BITS;
    localparam int GN     = 1 << GRID_BITS;
    localparam int LIMIT  = 3 * (GN + 64);
    localparam int LIM_W  = $clog2(LIMIT + 1);
    localparam int VW     = 10;  // voxel coordinate, signed, covers -256..255 and steps

    logic grid_mem [CELLS];
    logic [AW:0] clr_reg;
    logic        rd_reg;

    logic signed [VW-1:0] v_reg [3];
    logic [2:0]           neg_reg;
    logic [T_W-1:0]       tm_reg [3];
    logic [T_W-1:0]       td_reg [3];
    logic [15:0]          mag_reg [3];
    logic [12:0]          dist_reg [3];
    logic [2:0]           dph_reg;     // division phase: 0..5
    logic                 dbusy_reg;
    logic                 zero_reg;
    logic [LIM_W-1:0]     n_reg;
    logic [1:0]           ax_reg;
    logic                 hit_reg;
    logic [2:0]           face_reg;
    logic [3:0]           hx_reg, hy_reg, hz_reg;

    logic [1:0] ax_sel;
    logic [T_W:0] tsum;
    logic signed [VW-1:0] v_step;
    logic signed [VW-1:0] v_nx [3];
    logic div_start, div_done;
    logic [30:0] div_num;
    logic [15:0] div_den;
    logic [12:0] div_dist;
    logic [T_W-1:0] div_q;
    logic [AW-1:0] rd_addr;
    logic in_g [3];
    logic signed [DIR_W-1:0] dsel [3];
    logic signed [POS_W-1:0] psel [3];

    assign dsel[0] = dir_x; assign dsel[1] = dir_y; assign dsel[2] = dir_z;
    assign psel[0] = pos_x; assign psel[1] = pos_y; assign psel[2] = pos_z;

    // Axis with smallest t_max.
    always_comb begin
        if (tm_reg[0] < tm_reg[1]) ax_sel = (tm_reg[0] < tm_reg[2]) ? 2'd0 : 2'd2;
        else                       ax_sel = (tm_reg[1] < tm_reg[2]) ? 2'd1 : 2'd2;
        tsum   = {1'b0, tm_reg[ax_sel]} + {1'b0, td_reg[ax_sel]};
        v_step = neg_reg[ax_sel] ? v_reg[ax_sel] - VW'(1) : v_reg[ax_sel] + VW'(1);
    end

    // Read address follows the voxel being stepped into, so the lookup is ready after the step.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_g[i] = (v_reg[i] >= 0) && (v_reg[i] < VW'(GN));
            v_nx[i] = (ax_sel == 2'(i)) ? v_step : v_reg[i];
        end
        rd_addr = {v_nx[0][GRID_BITS-1:0], v_nx[1][GRID_BITS-1:0],
                   v_nx[2][GRID_BITS-1:0]};
    end

    // Memory: clearing pass, writes, registered read.
    always_ff @(posedge aclk) begin
        if (!clr_reg[AW]) grid_mem[clr_reg[AW-1:0]] <= 1'b0;
        else if (cmd.wr && (vox_x >> GRID_BITS) == 4'd0 && (vox_y >> GRID_BITS) == 4'd0 &&
                 (vox_z >> GRID_BITS) == 4'd0)
            grid_mem[{vox_x[GRID_BITS-1:0], vox_y[GRID_BITS-1:0],
                      vox_z[GRID_BITS-1:0]}] <= solid;
        rd_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) clr_reg <= '0;
        else if (!clr_reg[AW]) clr_reg <= clr_reg + 1'b1;
    end

    // Divider schedule: phases 0..2 t_delta, 3..5 t_max.
    always_comb begin
        case (dph_reg)
            3'd0, 3'd3: div_den = mag_reg[0];
            3'd1, 3'd4: div_den = mag_reg[1];
            default:    div_den = mag_reg[2];
        endcase
        case (dph_reg)
            3'd3:    div_dist = dist_reg[0];
            3'd4:    div_dist = dist_reg[1];
            default: div_dist = dist_reg[2];
        endcase
        div_num = (dph_reg < 3'd3) ? 31'h40000000 : {div_dist, 18'd0};
    end

    vgrt_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .done(div_done), .quo(div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dph_reg   <= '0;
        end else if (cmd.load) begin
            dbusy_reg <= 1'b1;
            dph_reg   <= '0;
        end else if (dbusy_reg && div_done && !div_start) begin
            if (dph_reg == 3'd5) dbusy_reg <= 1'b0;
            else dph_reg <= dph_reg + 3'd1;
        end
    end
    logic started_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) started_reg <= 1'b0;
        else started_reg <= cmd.load || (dbusy_reg && div_done && !started_reg);
    end
    // Start: the cycle after load, or after a phase result is stored while phases remain.
    assign div_start = dbusy_reg && started_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            zero_reg <= (dir_x == '0) || (dir_y == '0) || (dir_z == '0);
            n_reg    <= '0;
            hit_reg  <= 1'b0;
            face_reg <= FACE_POS_X;
            hx_reg <= '0; hy_reg <= '0; hz_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                logic [20:0] b;
                b = 21'(21'(signed'(psel[i])) + 21'd2048 + 21'h100000);
                v_reg[i]   <= VW'(signed'({1'b0, b[20:12]}) - 10'sd256);
                neg_reg[i] <= dsel[i][DIR_W-1];
                mag_reg[i] <= dsel[i][DIR_W-1] ? 16'(-dsel[i]) : dsel[i];
                dist_reg[i] <= dsel[i][DIR_W-1] ? {1'b0, b[11:0]}
                                                : 13'd4096 - {1'b0, b[11:0]};
            end
        end else if (dbusy_reg && div_done && !div_start) begin
            if (dph_reg < 3'd3) td_reg[dph_reg[1:0]] <= div_q;
            else tm_reg[2'(dph_reg - 3'd3)] <= div_q;
        end else if (cmd.step) begin
            v_reg[ax_sel]  <= v_step;
            tm_reg[ax_sel] <= tsum[T_W] ? T_MAXVAL : tsum[T_W-1:0];
            ax_reg         <= ax_sel;
            n_reg          <= n_reg + 1'b1;
        end
        if (hit_set) begin
            hit_reg  <= 1'b1;
            hx_reg   <= 4'(v_reg[0]);
            hy_reg   <= 4'(v_reg[1]);
            hz_reg   <= 4'(v_reg[2]);
            face_reg <= {ax_reg, neg_reg[ax_reg]};
        end
    end

    always_comb begin
        sts          = '0;
        sts.clr_done = clr_reg[AW];
        sts.div_done = !dbusy_reg && !cmd.load;
        sts.zero_dir = zero_reg;
        sts.out_grid = !(in_g[0] && in_g[1] && in_g[2]);
        sts.solid    = rd_reg;
        sts.limit    = !rd_reg && (n_reg >= LIM_W'(LIMIT));
    end

    assign hit   = hit_reg;
    assign hit_x = hx_reg;
    assign hit_y = hy_reg;
    assign hit_z = hz_reg;
    assign face  = face_reg;
endmodule

// ===== src/voxel_grid_ray_traversal_top.sv =====
// Voxel grid ray traversal: 3D DDA walk over a 16-cube occupancy grid.
// Writes go straight to the grid; a cast runs six divisions, then a step/lookup loop.
// Throughput: one item at a time; the serial divider and step/lookup loop set the rate.
// Reset: aresetn low clears control; then a clearing pass writes every grid cell
// to zero, emptying the grid while s_tready stays low.
`timescale 1ns / 1ps
module voxel_grid_ray_traversal_top import vgrt_pkg::*; #(
    parameter int GRID_BITS = GRID_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: vox_x, vox_y, vox_z, solid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
    input  logic [111:0] s_tdata,
    // tuser: action
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: hit, hit_x, hit_y, hit_z, face
    output logic [15:0]  m_tdata
);
    vgrt_cmd_t cmd;
    vgrt_sts_t sts;
    logic hit_set;
    logic hit;
    logic [3:0] hx, hy, hz;
    logic [2:0] face;

    vgrt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_action(s_tuser), .in_ready(s_tready),
        .res_valid(m_tvalid), .res_hit_set(hit_set), .res_ready(m_tready),
        .cmd(cmd), .sts(sts)
    );

    vgrt_dp #(.GRID_BITS(GRID_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .vox_x(s_tdata[3:0]), .vox_y(s_tdata[7:4]), .vox_z(s_tdata[11:8]),
        .solid(s_tdata[12]),
        .pos_x(s_tdata[29:13]), .pos_y(s_tdata[46:30]), .pos_z(s_tdata[63:47]),
        .dir_x(s_tdata[79:64]), .dir_y(s_tdata[95:80]), .dir_z(s_tdata[111:96]),
        .hit_set(hit_set),
        .hit(hit), .hit_x(hx), .hit_y(hy), .hit_z(hz), .face(face)
    );

    assign m_tdata = {face, hz, hy, hx, hit};

    // Result beat only while the input side is stalled.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready)) else $error("result and accept overlap");
    // A cast beat never yields a result in the next cycle.
    a_cast: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> !m_tvalid) else $error("early result");
endmodule
